>>> sv/totp_pkg.sv
package totp_pkg;

  localparam int KeyBytesDef = 64;
  localparam int MaxDriftDef = 15;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_GENERATE = 2'd1,
    CMD_VALIDATE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DIGITS  = 3'd0,
    REG_STEP    = 3'd1,
    REG_BACK    = 3'd2,
    REG_FORWARD = 3'd3,
    REG_KEYLEN  = 3'd4
  } reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  key_slot;
    logic [31:0] key_word;
    logic [63:0] time_or_counter;
    logic [26:0] token;
  } totp_in_t;

  typedef struct packed {
    logic [26:0] code;
    logic        matched;
    logic [63:0] match_counter;
  } totp_out_t;

  typedef logic [31:0] word_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t iv_word(input logic [2:0] i);
    case (i)
      3'd0:    iv_word = 32'h67452301;
      3'd1:    iv_word = 32'hEFCDAB89;
      3'd2:    iv_word = 32'h98BADCFE;
      3'd3:    iv_word = 32'h10325476;
      default: iv_word = 32'hC3D2E1F0;
    endcase
  endfunction

endpackage

>>> sv/totp_sha1_core.sv
// One SHA-1 compression, one round per cycle, chain kept here.
module totp_sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  init_i,
  input  logic                  start_i,
  input  logic [15:0][31:0]     block_i,
  output logic                  done_o,
  output logic [4:0][31:0]      chain_o
);
  import totp_pkg::*;

  word_t        w_q [16];
  word_t        a_q, b_q, c_q, d_q, e_q;
  word_t        h_q [5];
  logic [6:0]   t_q;
  logic         run_q;
  logic         done_q;

  word_t        w_new, wt, f, k, tmp;
  logic [3:0]   ti;

  assign ti = t_q[3:0];

  always_comb begin
    w_new = rotl(w_q[ti - 4'd3] ^ w_q[ti - 4'd8] ^ w_q[ti - 4'd14] ^ w_q[ti], 1);
    wt = (t_q < 7'd16) ? w_q[ti] : w_new;
    if (t_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (t_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;            k = 32'h6ED9EBA1;
    end else if (t_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;            k = 32'hCA62C1D6;
    end
    tmp = rotl(a_q, 5) + f + e_q + k + wt;
  end

  // start_i with init_i begins a new hash from the IV
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      t_q    <= '0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      e_q    <= '0;
      for (int i = 0; i < 5; i++) h_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        for (int i = 0; i < 16; i++) w_q[i] <= block_i[i];
        if (init_i) begin
          for (int i = 0; i < 5; i++) h_q[i] <= iv_word(3'(i));
          a_q <= iv_word(3'd0); b_q <= iv_word(3'd1); c_q <= iv_word(3'd2);
          d_q <= iv_word(3'd3); e_q <= iv_word(3'd4);
        end else begin
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
        end
        t_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (t_q >= 7'd16) w_q[ti] <= w_new;
        e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= tmp;
        if (t_q == 7'd79) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
          h_q[0] <= h_q[0] + tmp;
          h_q[1] <= h_q[1] + a_q;
          h_q[2] <= h_q[2] + rotl(b_q, 30);
          h_q[3] <= h_q[3] + c_q;
          h_q[4] <= h_q[4] + d_q;
        end else begin
          t_q <= t_q + 7'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  always_comb for (int i = 0; i < 5; i++) chain_o[i] = h_q[i];
endmodule

>>> sv/totp_code_check.sv
// totp_code_check: HOTP/TOTP engine on HMAC-SHA1.
// Command channel: a word is taken when start is high and busy is low.
// Load commands store one key word and give no result.
// Generate returns code for the given counter; validate divides the time by
// time_step, then tries counters current-back .. current+forward in order and
// reports the first match with its counter, else matched = 0.
// Each hashed candidate runs four SHA-1 compressions on one shared round
// unit, then truncation and a bit-serial mod.
// The time division of each validate is bit-serial.
// Generate and validate hold busy until the result; done_o rises as busy
// falls, and a new word is taken only while busy is low, one command at a
// time.
// done_o is high for one cycle with the result on res_o; it cannot be held
// off, the receiver must take it then.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are allowed only while idle.
// Reset restores register defaults and idles the sequencer; key words are
// undefined until loaded.
module totp_code_check #(
  parameter int KEY_BYTES = totp_pkg::KeyBytesDef,
  parameter int MAX_DRIFT = totp_pkg::MaxDriftDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  totp_pkg::totp_in_t          cmd_i,
  input  logic                        cfg_we_i,
  input  logic [totp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [totp_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        done_o,
  output totp_pkg::totp_out_t         res_o
);
  import totp_pkg::*;

  localparam int DW = $clog2(MAX_DRIFT + 1);
  localparam int WW = DW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CAND, S_H1, S_H2, S_H3, S_H4, S_TRUNC, S_MOD, S_CMP, S_OUT
  } state_e;

  state_e      state_q;
  logic [3:0]  digits_q;
  logic [30:0] step_q;
  logic [3:0]  back_q, fwd_q;
  logic [6:0]  klen_q;
  word_t       key_q [16];

  logic        val_q;
  logic [26:0] token_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [6:0]  cnt_q;
  logic [WW-1:0] idx_q;
  logic [63:0] cand_q;
  logic [4:0][31:0] inner_q;
  logic [31:0] bin_q;
  logic        done_q;
  totp_out_t   res_q;

  logic        sha_init, sha_start, sha_done;
  logic [15:0][31:0] sha_blk;
  logic [4:0][31:0]  chain;

  logic [DW-1:0] back_s, fwd_s;
  logic [6:0]    len_s;
  logic [15:0][31:0] kw;
  logic [31:0]   modv;
  logic [30:0]   step_s;

  assign back_s = (32'(back_q) > MAX_DRIFT) ? DW'(MAX_DRIFT) : DW'(back_q);
  assign fwd_s  = (32'(fwd_q) > MAX_DRIFT) ? DW'(MAX_DRIFT) : DW'(fwd_q);
  assign len_s  = (32'(klen_q) > KEY_BYTES) ? 7'(KEY_BYTES) : klen_q;
  assign step_s = (step_q == '0) ? 31'd1 : step_q;

  always_comb begin
    case (digits_q)
      4'd7:    modv = 32'd10000000;
      4'd8:    modv = 32'd100000000;
      default: modv = 32'd1000000;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        kw[i][31-8*j -: 8] = (7'(i * 4 + j) < len_s) ? key_q[i][31-8*j -: 8] : 8'h00;
      end
    end
  end

  always_comb begin
    sha_blk = '0;
    case (state_q)
      S_H1: for (int i = 0; i < 16; i++) sha_blk[i] = kw[i] ^ 32'h36363636;
      S_H2: begin
        sha_blk[0] = cand_q[63:32]; sha_blk[1] = cand_q[31:0];
        sha_blk[2] = 32'h80000000;  sha_blk[15] = 32'd576;
      end
      S_H3: for (int i = 0; i < 16; i++) sha_blk[i] = kw[i] ^ 32'h5c5c5c5c;
      S_H4: begin
        for (int i = 0; i < 5; i++) sha_blk[i] = inner_q[i];
        sha_blk[5] = 32'h80000000;  sha_blk[15] = 32'd672;
      end
      default: sha_blk = '0;
    endcase
  end

  logic phase_q;

  totp_sha1_core u_sha (
    .clk_i, .rst_ni,
    .init_i(sha_init), .start_i(sha_start), .block_i(sha_blk),
    .done_o(sha_done), .chain_o(chain)
  );

  // truncation byte pick
  logic [159:0] mac;
  logic [3:0]   off;
  logic [31:0]  picked;
  assign mac = {chain[0], chain[1], chain[2], chain[3], chain[4]};
  assign off = chain[4][3:0];
  assign picked = mac[159 - 8*off -: 32];

  // divide step
  logic [32:0] rtry;
  assign rtry = {rem_q, quo_q[63]} - {2'b0, step_s};

  // candidate window
  logic [WW-1:0] last;
  logic          skip;
  logic [63:0]   cval;
  logic [64:0]   sum;
  assign last = WW'(back_s) + WW'(fwd_s);
  always_comb begin
    skip = 1'b0; cval = '0; sum = '0;
    if (idx_q < WW'(back_s)) begin
      sum = {1'b0, quo_q} - 65'(WW'(back_s) - idx_q);
      skip = sum[64];
    end else begin
      sum = {1'b0, quo_q} + 65'(idx_q - WW'(back_s));
      skip = sum[64];
    end
    cval = sum[63:0];
  end

  // bit-serial mod on 31-bit value
  logic [32:0] mtry;
  assign mtry = {rem_q[31:0], bin_q[30]} - {1'b0, modv};

  always_ff @(posedge clk_i) begin
    if (start && !busy && cmd_e'(cmd_i.command) == CMD_LOAD) begin
      key_q[cmd_i.key_slot] <= cmd_i.key_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      digits_q <= 4'd6;
      step_q   <= 31'd30;
      back_q   <= 4'd1;
      fwd_q    <= 4'd1;
      klen_q   <= 7'd20;
      done_q   <= 1'b0;
      phase_q  <= 1'b0;
      val_q    <= 1'b0;
      token_q  <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      cand_q   <= '0;
      inner_q  <= '0;
      bin_q    <= '0;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DIGITS:  digits_q <= cfg_data_i[3:0];
          REG_STEP:    step_q   <= cfg_data_i[30:0];
          REG_BACK:    back_q   <= cfg_data_i[3:0];
          REG_FORWARD: fwd_q    <= cfg_data_i[3:0];
          REG_KEYLEN:  klen_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            token_q <= cmd_i.token;
            case (cmd_e'(cmd_i.command))
              CMD_GENERATE: begin
                val_q <= 1'b0; cand_q <= cmd_i.time_or_counter;
                idx_q <= '0; quo_q <= '0; state_q <= S_H1; phase_q <= 1'b0;
              end
              CMD_VALIDATE: begin
                val_q <= 1'b1; quo_q <= cmd_i.time_or_counter; rem_q <= '0;
                cnt_q <= '0; idx_q <= '0; state_q <= S_DIV;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (!rtry[32]) begin
            rem_q <= rtry[31:0]; quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], quo_q[63]}; quo_q <= {quo_q[62:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_q <= S_CAND;
        end
        S_CAND: begin
          if (skip) begin
            if (idx_q == last) state_q <= S_OUT;
            idx_q <= idx_q + WW'(1);
          end else begin
            cand_q <= cval; state_q <= S_H1; phase_q <= 1'b0;
          end
        end
        S_H1, S_H2, S_H3, S_H4: begin
          if (!phase_q) phase_q <= 1'b1;
          else if (sha_done) begin
            phase_q <= 1'b0;
            if (state_q == S_H2) inner_q <= chain;
            state_q <= (state_q == S_H1) ? S_H2 : (state_q == S_H2) ? S_H3 :
                       (state_q == S_H3) ? S_H4 : S_TRUNC;
          end
        end
        S_TRUNC: begin
          bin_q <= {1'b0, picked[30:0]}; rem_q <= '0; cnt_q <= '0;
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (!mtry[32]) rem_q <= mtry[31:0];
          else rem_q <= {rem_q[30:0], bin_q[30]};
          bin_q <= {bin_q[30:0], 1'b0};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd30) state_q <= S_CMP;
        end
        S_CMP: begin
          if (!val_q) begin
            res_q <= '{code: rem_q[26:0], matched: 1'b0, match_counter: '0};
            done_q <= 1'b1; state_q <= S_IDLE;
          end else if (rem_q == {5'b0, token_q}) begin
            res_q <= '{code: '0, matched: 1'b1, match_counter: cand_q};
            done_q <= 1'b1; state_q <= S_IDLE;
          end else if (idx_q == last) begin
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + WW'(1); state_q <= S_CAND;
          end
        end
        S_OUT: begin
          res_q <= '{code: '0, matched: 1'b0, match_counter: '0};
          done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // core start: pulse on the first cycle of each hash state
  logic core_go;
  assign core_go = (state_q == S_H1 || state_q == S_H2 || state_q == S_H3 ||
                    state_q == S_H4) && !phase_q;
  logic core_init;
  assign core_init = core_go && (state_q == S_H1 || state_q == S_H3);

  assign sha_start = core_go;
  assign sha_init  = core_init;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
